[src/spa_pkg.sv]
// Shared constants and types for the sparse polynomial adder.
package spa_pkg;

  localparam int unsigned MaxTerms = 32;

  localparam int unsigned CoeffW = 32;
  localparam int unsigned PowerW = 16;

  // Command codes carried on the slave-side tuser
  localparam logic [1:0] CmdLoadA = 2'd0;
  localparam logic [1:0] CmdLoadB = 2'd1;
  localparam logic [1:0] CmdAdd   = 2'd2;

  typedef struct packed {
    logic        [PowerW-1:0] power;
    logic signed [CoeffW-1:0] coeff;
  } term_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_MERGE = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

endpackage

[src/sparse_polynomial_add.sv]
// Sparse polynomial adder: term stores, merge sequencer and output register.
// Terms are loaded one transaction per cycle into store A or B while no add
// is running (zero coefficients are ignored, terms beyond MAX_TERMS are
// dropped and flagged). An add transaction walks both stores in a single
// shared compare/add step: each step addresses the heads (S_FETCH), then
// compares the registered read data and adds (S_MERGE). An add keeps
// s_axis_tready low until a last fetch and compare find both stores spent
// and the final term is handed on; the steps consumed number at most
// count_a + count_b, and the master side holding tready low stretches the
// add further. Terms leave in increasing exponent order if each store was
// loaded in that order; the last one carries tlast. One term is held back
// until the next is known so that tlast can be set, and an empty sum gives a
// single transaction with the empty flag set. Both stores are emptied once
// the final transaction of a sum has been handed to the output register.
module sparse_polynomial_add #(
  parameter int unsigned MAX_TERMS = spa_pkg::MaxTerms
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // [31:0] coeff, [47:32] power
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  // master side
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] sum_coeff, [47:32] sum_power
  output logic        m_axis_tlast,   // last
  output logic [2:0]  m_axis_tuser    // [0] empty_res, [1] overflow, [2] saturated
);

  localparam int unsigned AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CW = $clog2(MAX_TERMS + 1);
  localparam logic [CW-1:0] CountMax = CW'(MAX_TERMS);

  spa_pkg::state_e state_q, state_d;

  spa_pkg::term_t mem_a [MAX_TERMS];
  spa_pkg::term_t mem_b [MAX_TERMS];
  spa_pkg::term_t rd_a_q, rd_b_q, in_term;

  logic [CW-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CW-1:0] idx_a_q, idx_a_d, idx_b_q, idx_b_d;
  logic          lost_q, lost_d;

  logic                               pend_valid_q, pend_valid_d;
  spa_pkg::term_t                     pend_q, pend_d;
  logic                               pend_sat_q, pend_sat_d;

  logic           out_valid_q, out_valid_d;
  spa_pkg::term_t out_q, out_d;
  logic           out_last_q, out_last_d;
  logic           out_empty_q, out_empty_d;
  logic           out_ovf_q, out_ovf_d;
  logic           out_sat_q, out_sat_d;

  logic accept, load_a, load_b, full_a, full_b, coeff_nz, out_free;
  logic a_live, b_live, take_a, take_b;
  logic signed [spa_pkg::CoeffW:0] wide_sum;
  logic        [spa_pkg::CoeffW-1:0] step_coeff;
  logic step_sat, step_keep;

  assign in_term  = spa_pkg::term_t'(s_axis_tdata);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign coeff_nz = (in_term.coeff != '0);
  assign full_a   = (cnt_a_q >= CountMax);
  assign full_b   = (cnt_b_q >= CountMax);
  assign load_a   = accept && (s_axis_tuser == spa_pkg::CmdLoadA) && coeff_nz && !full_a;
  assign load_b   = accept && (s_axis_tuser == spa_pkg::CmdLoadB) && coeff_nz && !full_b;
  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == spa_pkg::S_IDLE);

  // Term stores: one write port for loads, one registered read at the head index
  always_ff @(posedge clk_i) begin
    if (load_a) begin
      mem_a[cnt_a_q[AW-1:0]] <= in_term;
    end
    if (load_b) begin
      mem_b[cnt_b_q[AW-1:0]] <= in_term;
    end
    rd_a_q <= mem_a[idx_a_q[AW-1:0]];
    rd_b_q <= mem_b[idx_b_q[AW-1:0]];
  end

  // Shared compare / saturating add step on the two heads
  always_comb begin
    a_live   = (idx_a_q < cnt_a_q);
    b_live   = (idx_b_q < cnt_b_q);
    take_a   = a_live && (!b_live || (rd_a_q.power <= rd_b_q.power));
    take_b   = b_live && (!a_live || (rd_b_q.power <= rd_a_q.power));
    wide_sum = {rd_a_q.coeff[spa_pkg::CoeffW-1], rd_a_q.coeff} +
               {rd_b_q.coeff[spa_pkg::CoeffW-1], rd_b_q.coeff};
    step_sat   = 1'b0;
    step_coeff = rd_a_q.coeff;
    priority if (take_a && take_b) begin
      if (wide_sum[spa_pkg::CoeffW] != wide_sum[spa_pkg::CoeffW-1]) begin
        step_sat   = 1'b1;
        step_coeff = wide_sum[spa_pkg::CoeffW] ? {1'b1, {(spa_pkg::CoeffW-1){1'b0}}}
                                               : {1'b0, {(spa_pkg::CoeffW-1){1'b1}}};
      end else begin
        step_coeff = wide_sum[spa_pkg::CoeffW-1:0];
      end
    end else if (take_b) begin
      step_coeff = rd_b_q.coeff;
    end else begin
      step_coeff = rd_a_q.coeff;
    end
    step_keep = (step_coeff != '0);
  end

  always_comb begin
    state_d      = state_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    idx_a_d      = idx_a_q;
    idx_b_d      = idx_b_q;
    lost_d       = lost_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    pend_sat_d   = pend_sat_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_d        = out_q;
    out_last_d   = out_last_q;
    out_empty_d  = out_empty_q;
    out_ovf_d    = out_ovf_q;
    out_sat_d    = out_sat_q;

    unique case (state_q)
      spa_pkg::S_IDLE: begin
        if (load_a) begin
          cnt_a_d = cnt_a_q + CW'(1);
        end
        if (load_b) begin
          cnt_b_d = cnt_b_q + CW'(1);
        end
        if (accept && coeff_nz &&
            (((s_axis_tuser == spa_pkg::CmdLoadA) && full_a) ||
             ((s_axis_tuser == spa_pkg::CmdLoadB) && full_b))) begin
          lost_d = 1'b1;
        end
        if (accept && (s_axis_tuser == spa_pkg::CmdAdd)) begin
          idx_a_d      = '0;
          idx_b_d      = '0;
          pend_valid_d = 1'b0;
          state_d      = spa_pkg::S_FETCH;
        end
      end
      spa_pkg::S_FETCH: begin
        state_d = spa_pkg::S_MERGE;
      end
      spa_pkg::S_MERGE: begin
        if (!a_live && !b_live) begin
          state_d = spa_pkg::S_FLUSH;
        end else if (!(step_keep && pend_valid_q && !out_free)) begin
          // hand the held term on, hold the new one until its successor is known
          if (step_keep) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
              out_last_d  = 1'b0;
              out_empty_d = 1'b0;
              out_ovf_d   = lost_q;
              out_sat_d   = pend_sat_q;
            end
            pend_valid_d = 1'b1;
            pend_d.coeff = step_coeff;
            pend_d.power = take_a ? rd_a_q.power : rd_b_q.power;
            pend_sat_d   = step_sat;
          end
          if (take_a) begin
            idx_a_d = idx_a_q + CW'(1);
          end
          if (take_b) begin
            idx_b_d = idx_b_q + CW'(1);
          end
          state_d = spa_pkg::S_FETCH;
        end
      end
      spa_pkg::S_FLUSH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_last_d  = 1'b1;
          out_ovf_d   = lost_q;
          if (pend_valid_q) begin
            out_d       = pend_q;
            out_empty_d = 1'b0;
            out_sat_d   = pend_sat_q;
          end else begin
            out_d       = '0;
            out_empty_d = 1'b1;
            out_sat_d   = 1'b0;
          end
          pend_valid_d = 1'b0;
          cnt_a_d      = '0;
          cnt_b_d      = '0;
          lost_d       = 1'b0;
          state_d      = spa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = spa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= spa_pkg::S_IDLE;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      idx_a_q      <= '0;
      idx_b_q      <= '0;
      lost_q       <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      idx_a_q      <= idx_a_d;
      idx_b_q      <= idx_b_d;
      lost_q       <= lost_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    pend_sat_q  <= pend_sat_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
    out_sat_q   <= out_sat_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_sat_q, out_ovf_q, out_empty_q};

endmodule

[bench/sparse_polynomial_add_tb.sv]
// Self-checking testbench for the sparse polynomial adder: directed table, then random sums.
`timescale 1ns / 100ps

module sparse_polynomial_add_tb;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned ItemTarget = 260;
  localparam int unsigned HoldOffCycles = 500;
  localparam int unsigned DrainCycles = 200;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam longint CoeffMax = 64'sd2147483647;
  localparam longint CoeffMin = -64'sd2147483648;

  // One result term as it leaves the master side
  typedef struct packed {
    logic signed [spa_pkg::CoeffW-1:0] coeff;
    logic        [spa_pkg::PowerW-1:0] power;
    logic                              last;
    logic                              empty_res;
    logic                              overflow;
    logic                              saturated;
  } sum_item_t;

  localparam sum_item_t EmptySum = {32'd0, 16'd0, 1'b1, 1'b1, 1'b0, 1'b0};

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] coeff;
    logic [15:0] power;
    bit          typed;
    sum_item_t   want;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // [31:0] coeff, [47:32] power
  logic [1:0]  s_axis_tuser;   // [1:0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [31:0] sum_coeff, [47:32] sum_power
  logic        m_axis_tlast;   // last
  logic [2:0]  m_axis_tuser;   // [0] empty_res, [1] overflow, [2] saturated

  // Predictor state: both term stores, their fill levels and the dropped-term flag
  spa_pkg::term_t store_a [spa_pkg::MaxTerms];
  spa_pkg::term_t store_b [spa_pkg::MaxTerms];
  int unsigned    fill_a;
  int unsigned    fill_b;
  bit             dropped;

  sum_item_t   sum_terms_due[$];
  plan_row_t   directed_plan[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned loaded_count = 0;
  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;

  sparse_polynomial_add u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] rand_coeff();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      1: v = 32'h8000_0000 + $urandom_range(0, 3);
      2, 3, 4, 5: v = $urandom();
      default: begin
        v = $urandom_range(1, 32'h000F_FFFF);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
    endcase
    if (v == 32'd0) v = 32'h0001_0000;
    return v;
  endfunction

  function automatic void load_term(input bit to_b, input logic [31:0] coeff,
                                    input logic [15:0] power);
    spa_pkg::term_t t;
    t.coeff = coeff;
    t.power = power;
    // Zero coefficients never reach the store and do not count as dropped
    if (coeff == 32'd0) return;
    if (!to_b) begin
      if (fill_a >= spa_pkg::MaxTerms) dropped = 1'b1;
      else begin
        store_a[fill_a] = t;
        fill_a++;
      end
    end else begin
      if (fill_b >= spa_pkg::MaxTerms) dropped = 1'b1;
      else begin
        store_b[fill_b] = t;
        fill_b++;
      end
    end
  endfunction

  function automatic sum_item_t term_item(input logic [31:0] coeff, input logic [15:0] power,
                                          input bit sat);
    return {coeff, power, 1'b0, 1'b0, dropped, sat};
  endfunction

  // Merge both stores in exponent order, then empty them
  function automatic void merge_sum(input bit typed, input sum_item_t want);
    sum_item_t   terms[$];
    sum_item_t   tail;
    int unsigned i;
    int unsigned j;
    longint      s;
    bit          sat;
    i = 0;
    j = 0;
    while (i < fill_a && j < fill_b) begin
      if (store_a[i].power < store_b[j].power) begin
        terms.push_back(term_item(store_a[i].coeff, store_a[i].power, 1'b0));
        i++;
      end else if (store_a[i].power > store_b[j].power) begin
        terms.push_back(term_item(store_b[j].coeff, store_b[j].power, 1'b0));
        j++;
      end else begin
        s = longint'($signed(store_a[i].coeff)) + longint'($signed(store_b[j].coeff));
        sat = 1'b0;
        if (s > CoeffMax) begin
          s = CoeffMax;
          sat = 1'b1;
        end else if (s < CoeffMin) begin
          s = CoeffMin;
          sat = 1'b1;
        end
        // A sum of exactly zero leaves no term
        if (s != 0) terms.push_back(term_item(s[31:0], store_a[i].power, sat));
        i++;
        j++;
      end
    end
    while (i < fill_a) begin
      terms.push_back(term_item(store_a[i].coeff, store_a[i].power, 1'b0));
      i++;
    end
    while (j < fill_b) begin
      terms.push_back(term_item(store_b[j].coeff, store_b[j].power, 1'b0));
      j++;
    end
    if (terms.size() == 0) begin
      tail = term_item(32'd0, 16'd0, 1'b0);
      tail.empty_res = 1'b1;
    end else begin
      tail = terms.pop_back();
    end
    tail.last = 1'b1;
    terms.push_back(tail);
    if (typed) sum_terms_due.push_back(want);
    else foreach (terms[k]) sum_terms_due.push_back(terms[k]);
    fill_a = 0;
    fill_b = 0;
    dropped = 1'b0;
  endfunction

  // Offer one transaction, hold it until accepted, then predict its results
  task automatic send_term(input logic [1:0] cmd, input logic [31:0] coeff,
                           input logic [15:0] power, input bit typed = 1'b0,
                           input sum_item_t want = '0);
    int unsigned gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {power, coeff};
    s_axis_tuser  <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    case (cmd)
      spa_pkg::CmdLoadA: load_term(1'b0, coeff, power);
      spa_pkg::CmdLoadB: load_term(1'b1, coeff, power);
      spa_pkg::CmdAdd:   merge_sum(typed, want);
      default: ;
    endcase
  endtask

  function automatic void plan(input logic [1:0] cmd, input logic [31:0] coeff,
                               input logic [15:0] power, input bit typed = 1'b0,
                               input sum_item_t want = '0);
    plan_row_t r;
    r.cmd   = cmd;
    r.coeff = coeff;
    r.power = power;
    r.typed = typed;
    r.want  = want;
    directed_plan.push_back(r);
  endfunction

  // One sum with random content; terms A, B or shared, loads interleaved, noise between
  task automatic random_sum(input int unsigned na, input int unsigned nb);
    spa_pkg::term_t la[$];
    spa_pkg::term_t lb[$];
    spa_pkg::term_t t;
    spa_pkg::term_t u;
    logic [15:0]    pw;
    int unsigned    pick;
    int unsigned    ia;
    int unsigned    ib;
    int unsigned    k;
    bit             wa;
    bit             wb;
    pw = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 15));
    while (la.size() < na || lb.size() < nb) begin
      pw += 16'($urandom_range(1, 4));
      wa = la.size() < na;
      wb = lb.size() < nb;
      pick = $urandom_range(0, 2);
      t.power = pw;
      t.coeff = rand_coeff();
      u.power = pw;
      u.coeff = rand_coeff();
      if (wa && (pick != 1 || !wb)) la.push_back(t);
      if (wb && (pick != 0 || !wa)) begin
        // Shared exponent: often cancel the A term outright
        if (wa && pick == 2 && $urandom_range(0, 2) == 0) u.coeff = -t.coeff;
        lb.push_back(u);
      end
    end
    // Break the exponent order now and then
    if ($urandom_range(0, 9) == 0 && la.size() >= 2) begin
      k = $urandom_range(0, la.size() - 2);
      t = la[k];
      la[k] = la[k+1];
      la[k+1] = t;
    end
    ia = 0;
    ib = 0;
    while (ia < la.size() || ib < lb.size()) begin
      if ($urandom_range(0, 19) == 0) begin
        if ($urandom_range(0, 1) != 0) send_term(CmdUnused, $urandom(), 16'($urandom()));
        else send_term(($urandom_range(0, 1) != 0) ? spa_pkg::CmdLoadB : spa_pkg::CmdLoadA,
                       32'd0, 16'($urandom()));
      end
      if (ib >= lb.size() || (ia < la.size() && $urandom_range(0, 1) != 0)) begin
        send_term(spa_pkg::CmdLoadA, la[ia].coeff, la[ia].power);
        ia++;
      end else begin
        send_term(spa_pkg::CmdLoadB, lb[ib].coeff, lb[ib].power);
        ib++;
      end
    end
    send_term(spa_pkg::CmdAdd, $urandom(), 16'($urandom()));
    loaded_count += na + nb + 1;
  endtask

  function automatic void check_output();
    sum_item_t want;
    sum_item_t got;
    got = {m_axis_tdata[31:0], m_axis_tdata[47:32], m_axis_tlast,
           m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2]};
    if (sum_terms_due.size() == 0) begin
      $error("unexpected result transaction: sum_coeff %h sum_power %h", got.coeff, got.power);
      fail_count++;
      return;
    end
    want = sum_terms_due.pop_front();
    if (got.coeff !== want.coeff) begin
      $error("sum_coeff: expected %h, actual %h", want.coeff, got.coeff);
      fail_count++;
    end
    if (got.power !== want.power) begin
      $error("sum_power: expected %h, actual %h", want.power, got.power);
      fail_count++;
    end
    if (got.last !== want.last) begin
      $error("last: expected %b, actual %b", want.last, got.last);
      fail_count++;
    end
    if (got.empty_res !== want.empty_res) begin
      $error("empty_res: expected %b, actual %b", want.empty_res, got.empty_res);
      fail_count++;
    end
    if (got.overflow !== want.overflow) begin
      $error("overflow: expected %b, actual %b", want.overflow, got.overflow);
      fail_count++;
    end
    if (got.saturated !== want.saturated) begin
      $error("saturated: expected %b, actual %b", want.saturated, got.saturated);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_output();
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("** sparse_polynomial_add: FAILED **");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin
    int unsigned gap;
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    int unsigned seq;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= spa_pkg::CmdLoadA;
    fill_a  = 0;
    fill_b  = 0;
    dropped = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Add straight after reset; coeff and power of an add are ignored
    plan(spa_pkg::CmdAdd, 32'h1234_5678, 16'hABCD, 1'b1, EmptySum);
    // Positive clip at the lowest exponent
    plan(spa_pkg::CmdLoadA, 32'h7FFF_FFFF, 16'h0000);
    plan(spa_pkg::CmdLoadB, 32'h0000_0001, 16'h0000);
    plan(spa_pkg::CmdAdd, 32'h0, 16'h0, 1'b1,
         {32'h7FFF_FFFF, 16'h0000, 1'b1, 1'b0, 1'b0, 1'b1});
    // Negative clip at the highest exponent
    plan(spa_pkg::CmdLoadA, 32'h8000_0000, 16'hFFFF);
    plan(spa_pkg::CmdLoadB, 32'hFFFF_FFFF, 16'hFFFF);
    plan(spa_pkg::CmdAdd, 32'hFFFF_FFFF, 16'hFFFF, 1'b1,
         {32'h8000_0000, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b1});
    // Cancelling terms leave an empty sum
    plan(spa_pkg::CmdLoadA, 32'h0005_0000, 16'd3);
    plan(spa_pkg::CmdLoadB, 32'hFFFB_0000, 16'd3);
    plan(spa_pkg::CmdAdd, 32'h0, 16'h0, 1'b1, EmptySum);
    // Zero coefficient and unused command change nothing
    plan(spa_pkg::CmdLoadA, 32'h0, 16'd7);
    plan(CmdUnused, 32'hFFFF_FFFF, 16'hFFFF);
    plan(spa_pkg::CmdAdd, 32'h0, 16'h0, 1'b1, EmptySum);
    // Unmatched, shared and tail terms
    plan(spa_pkg::CmdLoadA, 32'h0001_0000, 16'd1);
    plan(spa_pkg::CmdLoadB, 32'hFFFF_0000, 16'd2);
    plan(spa_pkg::CmdLoadA, 32'h0002_0000, 16'd4);
    plan(spa_pkg::CmdLoadB, 32'h0003_0000, 16'd4);
    plan(spa_pkg::CmdLoadA, 32'h0000_8000, 16'd9);
    plan(spa_pkg::CmdAdd, 32'h0, 16'h0);
    // Exponents out of order are merged as they stand
    plan(spa_pkg::CmdLoadA, 32'h0004_0000, 16'd10);
    plan(spa_pkg::CmdLoadA, 32'h0005_0000, 16'd2);
    plan(spa_pkg::CmdLoadB, 32'h0006_0000, 16'd5);
    plan(spa_pkg::CmdAdd, 32'h0, 16'h0);

    foreach (directed_plan[k])
      send_term(directed_plan[k].cmd, directed_plan[k].coeff, directed_plan[k].power,
                directed_plan[k].typed, directed_plan[k].want);

    // Stall the receiver while the first full stores are loaded and emitted
    hold_off_req = 1'b1;
    seq = 0;
    while (loaded_count < ItemTarget) begin
      calm = (seq == 0) || ($urandom_range(0, 4) == 0);
      if (seq == 0) random_sum(34, $urandom_range(0, 6));
      else if (seq == 1) random_sum($urandom_range(0, 6), 35);
      else if ($urandom_range(0, 14) == 0)
        random_sum($urandom_range(28, 36), $urandom_range(28, 36));
      else random_sum($urandom_range(0, 8), $urandom_range(0, 8));
      seq++;
    end
    s_axis_tvalid <= 1'b0;

    while (sum_terms_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** sparse_polynomial_add: PASSED **");
    end else begin
      $display("** sparse_polynomial_add: FAILED **");
    end
    $finish;
  end

endmodule

[sparse_polynomial_add.f]
src/spa_pkg.sv
src/sparse_polynomial_add.sv
bench/sparse_polynomial_add_tb.sv
